@@ rtl/html_entity_decoder_top_defines.svh @@
// Assertion macros for the checker file hed_chk.sv.
`ifndef HTML_ENTITY_DECODER_TOP_DEFINES_SVH
`define HTML_ENTITY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hed_pkg;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } hed_cmd_t;

  typedef struct packed {
    logic step_avail;
    logic step_emits;
    logic hold_valid;
    logic out_free;
  } hed_sts_t;

  localparam int NAME_NUM = 16;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [63:0] NAME_STR [NAME_NUM] = '{
    "amp", "lt", "gt", "quot", "apos", "nbsp", "mdash", "ndash",
    "hellip", "lsquo", "rsquo", "ldquo", "rdquo", "middot", "times", "copy"
  };

  localparam logic [3:0] NAME_LEN [NAME_NUM] = '{
    4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5,
    4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd5, 4'd4
  };

  localparam logic [7:0] NAME_REP [NAME_NUM] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20, 8'h2D, 8'h2D,
    8'h2E, 8'h27, 8'h27, 8'h22, 8'h22, 8'h2D, 8'h78, 8'h63
  };

  // Names sit right-justified in NAME_STR, first character most significant.
  function automatic logic name_char_hit(input logic [3:0] k, input logic [3:0] pos,
                                         input logic [7:0] c);
    logic [3:0] len;
    logic [3:0] sel;
    logic [7:0] ch;
    len = NAME_LEN[k];
    sel = len - pos - 4'd1;
    ch  = NAME_STR[k][{sel[2:0], 3'b000} +: 8];
    return (pos < len) && (ch == c);
  endfunction

endpackage
`default_nettype wire

@@ rtl/html_entity_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// HTML character reference decoder.
// Input channel in_valid/in_ready carries one text byte per beat (in_byte) and
// stream_end on the last byte of a stream. Output channel out_valid/out_ready
// carries decoded bytes (out_byte); run_last marks the final beat that one
// input beat causes. An input beat can cause no output beat (an opened
// reference), or up to MAX_REF_LEN + 1 beats when a reference fails.
// Config channel cfg_valid/cfg_ready writes decode_enabled; cfg_ready is
// always high. Write it only while the block is idle.
// Timing: a byte is taken while idle, then the sequencer steps through each byte
// of the working buffer, and a final flush step releases the last held result.
// The next byte is taken only after that flush, once the block is idle again.
// A failed reference replays its held bytes through the same sequencer, one byte
// per cycle while the receiver does not stall the hold register.
// The results are delayed by one hold register so run_last is known when a
// beat leaves; when the receiver stalls the sequencer waits on that register.
// Reset: synchronous, active high; clears any open reference, enables decoding.
module html_entity_decoder_top
  import hed_pkg::*;
#(
  parameter int MAX_REF_LEN = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       decode_enabled,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       stream_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last
);

  hed_cmd_t cmd;
  hed_sts_t sts;

  assign cfg_ready = 1'b1;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hed_dp #(
    .MAX_REF_LEN (MAX_REF_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .decode_enabled (decode_enabled),
    .in_byte        (in_byte),
    .stream_end     (stream_end),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .run_last       (run_last)
  );

endmodule
`default_nettype wire

@@ rtl/hed_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hed_ctrl
  import hed_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hed_sts_t sts,
  output hed_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.step_avail) begin
          // release the last held result, then go idle
          if (!sts.hold_valid || sts.out_free) begin
            cmd.flush  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = !sts.step_emits || !sts.hold_valid || sts.out_free;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hed_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hed_dp
  import hed_pkg::*;
#(
  parameter int MAX_REF_LEN = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       decode_enabled,
  input  wire logic [7:0] in_byte,
  input  wire logic       stream_end,
  input  wire hed_cmd_t   cmd,
  output hed_sts_t        sts,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last
);

  localparam int DEPTH = MAX_REF_LEN + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_OPEN   = 3'd2;
  localparam logic [2:0] OP_APPEND = 3'd3;
  localparam logic [2:0] OP_HIT    = 3'd4;

  logic [7:0]          pend [DEPTH];
  logic [CNT_W-1:0]    tot;
  logic [CNT_W-1:0]    pcount;
  logic                end_flag;
  logic                decode_on;
  logic                hold_valid;
  logic [7:0]          hold_byte;

  logic [NAME_NUM-1:0] mask;
  logic                is_num;
  logic                is_hex;
  logic                num_ok;
  logic [31:0]         val;

  logic [7:0]          cur;
  logic [CNT_W-1:0]    name_len;
  logic [3:0]          name_len4;
  logic                dec_ok;
  logic [3:0]          dec_val;
  logic                hex_ok;
  logic [3:0]          hex_val;
  logic [31:0]         val_dec;
  logic [NAME_NUM-1:0] named_hit;
  logic [7:0]          named_rep;
  logic [7:0]          num_rep;
  logic                ref_ok;
  logic [7:0]          hit_rep;
  logic [2:0]          op;
  logic                emits;
  logic                push;

  assign cur       = pend[pcount[IDX_W-1:0]];
  assign name_len  = pcount - CNT_W'(1);
  assign name_len4 = 4'(name_len);

  always_comb begin
    dec_ok  = (cur >= 8'h30) && (cur <= 8'h39);
    dec_val = 4'(cur - 8'h30);
    hex_ok  = 1'b1;
    hex_val = dec_val;
    if (dec_ok) begin
      hex_val = dec_val;
    end else if ((cur >= 8'h61) && (cur <= 8'h66)) begin
      hex_val = 4'(cur - 8'h57);
    end else if ((cur >= 8'h41) && (cur <= 8'h46)) begin
      hex_val = 4'(cur - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign val_dec = {val[28:0], 3'b000} + {val[30:0], 1'b0} + {28'd0, dec_val};

  always_comb begin
    named_rep = '0;
    for (int k = 0; k < NAME_NUM; k++) begin
      named_hit[k] = mask[k] && (NAME_LEN[k] == name_len4);
      if (named_hit[k]) begin
        named_rep = named_rep | NAME_REP[k];
      end
    end
  end

  always_comb begin
    if ((val >= 32'd32) && (val <= 32'd126)) begin
      num_rep = val[7:0];
    end else if (val == 32'd160) begin
      num_rep = CH_SPACE;
    end else begin
      num_rep = CH_QMARK;
    end
  end

  assign ref_ok  = is_num ? num_ok : (|named_hit);
  assign hit_rep = is_num ? num_rep : named_rep;

  always_comb begin
    op = OP_NONE;
    if (!decode_on) begin
      if (tot != '0) begin
        op = OP_HEAD;
      end
    end else if (tot > pcount) begin
      if (pcount == '0) begin
        op = (cur == CH_AMP) ? OP_OPEN : OP_HEAD;
      end else if (cur == CH_SEMI) begin
        op = ref_ok ? OP_HIT : OP_HEAD;
      end else if ((pcount >= CNT_W'(MAX_REF_LEN)) || (cur == CH_SPACE) ||
                   (cur == CH_LT)) begin
        op = OP_HEAD;
      end else begin
        op = OP_APPEND;
      end
    end else if (end_flag && (pcount != '0)) begin
      op = OP_HEAD;
    end
  end

  assign emits = (op == OP_HEAD) || (op == OP_HIT);
  assign push  = hold_valid && ((cmd.step && emits) || cmd.flush);

  assign sts.step_avail = (op != OP_NONE);
  assign sts.step_emits = emits;
  assign sts.hold_valid = hold_valid;
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tot        <= '0;
      pcount     <= '0;
      end_flag   <= 1'b0;
      decode_on  <= 1'b1;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        decode_on <= decode_enabled;
      end
      if (cmd.load) begin
        tot      <= tot + CNT_W'(1);
        end_flag <= stream_end;
      end
      if (cmd.step) begin
        unique case (op)
          OP_HEAD: begin
            tot    <= tot - CNT_W'(1);
            pcount <= '0;
          end
          OP_OPEN: pcount <= CNT_W'(1);
          OP_APPEND: pcount <= pcount + CNT_W'(1);
          OP_HIT: begin
            tot    <= '0;
            pcount <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.step && emits) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend[tot[IDX_W-1:0]] <= in_byte;
    end else if (cmd.step && (op == OP_HEAD)) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        pend[i] <= pend[i + 1];
      end
    end
    if (cmd.step && (op == OP_OPEN)) begin
      mask   <= '1;
      is_num <= 1'b0;
    end
    if (cmd.step && (op == OP_APPEND)) begin
      for (int k = 0; k < NAME_NUM; k++) begin
        mask[k] <= mask[k] & name_char_hit(4'(k), name_len4, cur);
      end
      if (pcount == CNT_W'(1)) begin
        is_num <= (cur == CH_HASH);
        is_hex <= 1'b0;
        num_ok <= 1'b1;
        val    <= '0;
      end else if (is_num) begin
        if ((pcount == CNT_W'(2)) && ((cur == CH_X_LO) || (cur == CH_X_UP))) begin
          is_hex <= 1'b1;
        end else if (is_hex) begin
          if (hex_ok) begin
            val <= {val[27:0], hex_val};
          end else begin
            num_ok <= 1'b0;
          end
        end else begin
          if (dec_ok) begin
            val <= val_dec;
          end else begin
            num_ok <= 1'b0;
          end
        end
      end
    end
    if (cmd.step && emits) begin
      hold_byte <= (op == OP_HIT) ? hit_rep : pend[0];
    end
    if (push) begin
      out_byte <= hold_byte;
      run_last <= cmd.flush;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hed_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "html_entity_decoder_top_defines.svh"
module hed_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_last
);

  `HED_ASSERT_NEXT(a_out_hold_valid, clk, rst, out_valid && !out_ready, out_valid, "output beat dropped while stalled")

  `HED_ASSERT_NEXT(a_out_hold_data, clk, rst, out_valid && !out_ready, $stable(out_byte) && $stable(run_last), "output payload changed while stalled")

  `HED_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input taken again right after an accept")

  `HED_ASSERT_NOW(a_busy_mid_run, clk, rst, out_valid && !run_last, !in_ready, "idle while a run is not finished")

endmodule

bind html_entity_decoder_top hed_chk u_hed_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .run_last  (run_last)
);
`default_nettype wire
